@@ src/slb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slb_pkg
// Types, constants and the square root table for the soft light blend block.
// ----------------------------------------------------------------------------
package slb_pkg;

    // channel_mode codes; code 3 is treated like RGBA
    localparam logic [1:0] MODE_GRAY = 2'd0;
    localparam logic [1:0] MODE_RGB  = 2'd1;
    localparam logic [1:0] MODE_RGBA = 2'd2;

    // 255^2, divisor of the low branch square term
    localparam logic [15:0] DIV_C   = 16'd65025;
    // floor(2^40 / 65025), reciprocal used against (Y >> 8) with a >> 32
    localparam logic [24:0] RECIP_M = 25'd16909060;

    typedef struct packed {
        logic [7:0] base_red;
        logic [7:0] base_green;
        logic [7:0] base_blue;
        logic [7:0] base_alpha;
        logic [7:0] blend_red;
        logic [7:0] blend_green;
        logic [7:0] blend_blue;
        logic       last_pixel;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       out_last;
    } t_pix_out;

    // per-pixel side data that rides along the pipeline
    typedef struct packed {
        logic       en_gb;
        logic       en_alpha;
        logic [7:0] alpha;
        logic       last;
    } t_side;

    typedef logic [16:0] t_root_tbl [256];

    // S(a) = floor(sqrt(floor(a * 2^32 / 255))), Q1.16; built at elaboration
    function automatic t_root_tbl f_root_tbl();
        t_root_tbl   tbl;
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bt;
        for (int i = 0; i < 256; i++) begin
            x   = (64'(i) << 32) / 64'd255;
            res = 64'd0;
            bt  = 64'd1 << 34;
            for (int j = 0; j < 18; j++) begin
                if (bt > x) bt = bt >> 2;
            end
            for (int j = 0; j < 18; j++) begin
                if (bt != 64'd0) begin
                    if (x >= res + bt) begin
                        x   = x - (res + bt);
                        res = (res >> 1) + bt;
                    end else begin
                        res = res >> 1;
                    end
                    bt = bt >> 2;
                end
            end
            tbl[i] = res[16:0];
        end
        return tbl;
    endfunction

    localparam t_root_tbl ROOT_TBL = f_root_tbl();

endpackage

@@ src/soft_light_blend_pixel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// soft_light_blend_pixel
// Soft light blend of one pixel per clock, three color lanes in parallel.
// ----------------------------------------------------------------------------
// A pixel taken with start runs through stages 1 to 7 and leaves with o_strobe.
// Throughput: one pixel per cycle; busy stays low, the seven-stage pipeline
// never stalls since results cannot be held off by the receiver.
// The reciprocal divide by 255^2 sets the depth (multiply, then correct).
// Reset clears all stage valid bits and sets channel_mode to RGBA.
// The square root table is constant logic and needs no clearing.
module soft_light_blend_pixel
    import slb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel in
    input  logic        start,
    output logic        busy,
    input  t_pix_in     i_pixel,
    // pixel out
    output logic        o_strobe,
    output t_pix_out    o_result,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NL = 3;

    // ---------------- configuration ----------------
    logic [1:0] r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RGBA;
        end else if (psel && penable && pwrite) begin
            r_mode <= pwdata[1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {30'd0, r_mode};
    assign busy   = 1'b0;

    // paddr only holds byte offsets within the single register
    logic unused_addr;
    assign unused_addr = ^paddr;

    // ---------------- lane inputs ----------------
    logic [7:0] w_a [NL];
    logic [7:0] w_b [NL];

    always_comb begin
        w_a[0] = i_pixel.base_red;
        w_a[1] = i_pixel.base_green;
        w_a[2] = i_pixel.base_blue;
        w_b[0] = i_pixel.blend_red;
        w_b[1] = i_pixel.blend_green;
        w_b[2] = i_pixel.blend_blue;
    end

    // ---------------- valid and side line ----------------
    logic [7:1] r_vld;
    t_side      r_side [1:6];
    t_side      n_side;

    always_comb begin
        n_side.en_gb    = (r_mode != MODE_GRAY);
        n_side.en_alpha = (r_mode >= MODE_RGBA);
        n_side.alpha    = i_pixel.base_alpha;
        n_side.last     = i_pixel.last_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:1], start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[1] <= n_side;
        for (int s = 2; s <= 6; s++) begin
            r_side[s] <= r_side[s-1];
        end
    end

    // ---------------- stage 1: products and table ----------------
    // low branch (b <= 128): t1 = a*b, k = |255 - 2b|, neg when b == 128
    // high branch:           t1 = a*(255-b), k = 2b - 255
    logic [15:0] r1_aa   [NL];
    logic [7:0]  r1_k    [NL];
    logic [14:0] r1_t1   [NL];
    logic [16:0] r1_root [NL];
    logic        r1_low  [NL];
    logic        r1_neg  [NL];

    logic [7:0]  n1_bp   [NL];
    logic [7:0]  n1_k    [NL];
    logic        n1_low  [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            n1_low[l] = (w_b[l] <= 8'd128);
            if (n1_low[l]) begin
                n1_bp[l] = w_b[l];
                if (w_b[l] == 8'd128) n1_k[l] = 8'd1;
                else                  n1_k[l] = 8'd255 - {w_b[l][6:0], 1'b0};
            end else begin
                n1_bp[l] = 8'd255 - w_b[l];
                n1_k[l]  = 8'(({1'b0, w_b[l]} << 1) - 9'd255);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            r1_aa[l]   <= 16'(w_a[l]) * 16'(w_a[l]);
            r1_t1[l]   <= 15'(16'(w_a[l]) * 16'(n1_bp[l]));
            r1_k[l]    <= n1_k[l];
            r1_root[l] <= ROOT_TBL[w_a[l]];
            r1_low[l]  <= n1_low[l];
            r1_neg[l]  <= (w_b[l] == 8'd128);
        end
    end

    // ---------------- stage 2: shared multiplier ----------------
    // low: P = a*a*k ; high: T2 = S(a)*k (final)
    logic [23:0] r2_p   [NL];
    logic [14:0] r2_t1  [NL];
    logic        r2_low [NL];
    logic        r2_neg [NL];
    logic [16:0] n2_x   [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            n2_x[l] = r1_low[l] ? {1'b0, r1_aa[l]} : r1_root[l];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            r2_p[l]   <= 24'(25'(n2_x[l]) * 25'(r1_k[l]));
            r2_t1[l]  <= r1_t1[l];
            r2_low[l] <= r1_low[l];
            r2_neg[l] <= r1_neg[l];
        end
    end

    // ---------------- stage 3: Y = 511*P ----------------
    // P*65536/65025 = P + P*511/65025
    logic [32:0] r3_y   [NL];
    logic [23:0] r3_p   [NL];
    logic [14:0] r3_t1  [NL];
    logic        r3_low [NL];
    logic        r3_neg [NL];

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            r3_y[l]   <= (33'(r2_p[l]) << 9) - 33'(r2_p[l]);
            r3_p[l]   <= r2_p[l];
            r3_t1[l]  <= r2_t1[l];
            r3_low[l] <= r2_low[l];
            r3_neg[l] <= r2_neg[l];
        end
    end

    // ---------------- stage 4: reciprocal estimate ----------------
    // estimate is the true quotient or one below
    logic [16:0] r4_qe  [NL];
    logic [32:0] r4_y   [NL];
    logic [23:0] r4_p   [NL];
    logic [14:0] r4_t1  [NL];
    logic        r4_low [NL];
    logic        r4_neg [NL];
    logic [49:0] n4_prod [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            n4_prod[l] = 50'(r3_y[l][32:8]) * 50'(RECIP_M);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            r4_qe[l]  <= n4_prod[l][48:32];
            r4_y[l]   <= r3_y[l];
            r4_p[l]   <= r3_p[l];
            r4_t1[l]  <= r3_t1[l];
            r4_low[l] <= r3_low[l];
            r4_neg[l] <= r3_neg[l];
        end
    end

    // ---------------- stage 5: back-multiply ----------------
    logic [32:0] r5_qm  [NL];
    logic [16:0] r5_qe  [NL];
    logic [32:0] r5_y   [NL];
    logic [23:0] r5_p   [NL];
    logic [14:0] r5_t1  [NL];
    logic        r5_low [NL];
    logic        r5_neg [NL];

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            r5_qm[l]  <= 33'(r4_qe[l]) * 33'(DIV_C);
            r5_qe[l]  <= r4_qe[l];
            r5_y[l]   <= r4_y[l];
            r5_p[l]   <= r4_p[l];
            r5_t1[l]  <= r4_t1[l];
            r5_low[l] <= r4_low[l];
            r5_neg[l] <= r4_neg[l];
        end
    end

    // ---------------- stage 6: correct quotient, form T2 magnitude ----------------
    logic [24:0] r6_t2  [NL];
    logic [14:0] r6_t1  [NL];
    logic        r6_neg [NL];
    logic [32:0] n6_rem [NL];
    logic        n6_cor [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            n6_rem[l] = r5_y[l] - r5_qm[l];
            n6_cor[l] = (n6_rem[l] >= 33'(DIV_C));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < NL; l++) begin
            if (r5_low[l]) begin
                r6_t2[l] <= 25'(r5_p[l]) + 25'(r5_qe[l]) + 25'(n6_cor[l]);
            end else begin
                r6_t2[l] <= 25'(r5_p[l]);
            end
            r6_t1[l]  <= r5_t1[l];
            r6_neg[l] <= r5_neg[l];
        end
    end

    // ---------------- stage 7: sum, truncate, clamp ----------------
    logic [25:0] n7_sum [NL];
    logic [7:0]  n7_res [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            if (r6_neg[l]) begin
                n7_sum[l] = {2'b00, r6_t1[l], 9'd0} - {1'b0, r6_t2[l]};
            end else begin
                n7_sum[l] = {2'b00, r6_t1[l], 9'd0} + {1'b0, r6_t2[l]};
            end
            if (n7_sum[l][25])      n7_res[l] = 8'd0;
            else if (n7_sum[l][24]) n7_res[l] = 8'd255;
            else                    n7_res[l] = n7_sum[l][23:16];
        end
    end

    t_pix_out r_out;
    t_side    w_s6;

    assign w_s6 = r_side[6];

    always_ff @(posedge i_clk) begin
        r_out.out_red   <= n7_res[0];
        r_out.out_green <= w_s6.en_gb ? n7_res[1] : 8'd0;
        r_out.out_blue  <= w_s6.en_gb ? n7_res[2] : 8'd0;
        r_out.out_alpha <= w_s6.en_alpha ? w_s6.alpha : 8'd0;
        r_out.out_last  <= w_s6.last;
    end

    assign o_strobe = r_vld[7];
    assign o_result = r_out;

endmodule
